// File: rtl/pce_pkg.sv
package pce_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = 40;
    localparam int COORD_W = 32;
    localparam int POINT_W = 2 * COORD_W;

    localparam int LEN_W = 41;
    localparam int MUL_A_W = LEN_W;
    localparam int MUL_B_W = COORD_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam int SQRT_IN_W = 2 * LEN_W;
    localparam int SQRT_REM_W = LEN_W + 2;
    localparam int SQRT_STEPS = LEN_W;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    localparam int NUM_W = MUL_P_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      is_final;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      out_last;
        logic                      out_empty;
        logic                      out_overflow;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_RDP,
        S_RDQ,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_MPX,
        S_MVX,
        S_DVX,
        S_MPY,
        S_MVY,
        S_DVY,
        S_ERD,
        S_ELD,
        S_EEMP,
        S_HOLD
    } t_state;

endpackage

// File: rtl/pce_ram.sv
module pce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pce_mul.sv
module pce_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pce_pkg::MUL_A_W-1:0]   i_a,
    input  logic [pce_pkg::MUL_B_W-1:0]   i_b,
    output logic                          o_done,
    output logic [pce_pkg::MUL_P_W-1:0]   o_prod
);

    logic [pce_pkg::MUL_P_W-1:0]   r_a;
    logic [pce_pkg::MUL_B_W-1:0]   r_b;
    logic [pce_pkg::MUL_P_W-1:0]   r_acc;
    logic [pce_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= pce_pkg::MUL_P_W'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + (r_b[0] ? r_a : '0);
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pce_pkg::MUL_CNT_W'(pce_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/pce_sqrt.sv
module pce_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pce_pkg::SQRT_IN_W-1:0]   i_x,
    output logic                            o_done,
    output logic [pce_pkg::LEN_W-1:0]       o_root,
    output logic                            o_rem_nz
);

    logic [pce_pkg::SQRT_IN_W-1:0]  r_x;
    logic [pce_pkg::SQRT_REM_W-1:0] r_rem;
    logic [pce_pkg::LEN_W-1:0]      r_root;
    logic [pce_pkg::SQRT_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [pce_pkg::SQRT_REM_W-1:0] rem2;
    logic [pce_pkg::SQRT_REM_W-1:0] trial;
    logic                           ge;

    always_comb begin
        rem2  = {r_rem[pce_pkg::SQRT_REM_W-3:0], r_x[pce_pkg::SQRT_IN_W-1 -: 2]};
        trial = {r_root, 2'b01};
        ge    = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x    <= r_x << 2;
                r_rem  <= ge ? rem2 - trial : rem2;
                r_root <= {r_root[pce_pkg::LEN_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == pce_pkg::SQRT_CNT_W'(pce_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_root   = r_root;
    assign o_rem_nz = |r_rem;

endmodule

// File: rtl/pce_div.sv
module pce_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pce_pkg::NUM_W-1:0]     i_num,
    input  logic [pce_pkg::LEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [pce_pkg::COORD_W-1:0]   o_quo
);

    logic [pce_pkg::NUM_W-1:0]     r_num;
    logic [pce_pkg::LEN_W-1:0]     r_rem;
    logic [pce_pkg::COORD_W-1:0]   r_quo;
    logic [pce_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [pce_pkg::LEN_W:0]       rem2;
    logic                          ge;

    always_comb begin
        rem2 = {r_rem, r_num[pce_pkg::NUM_W-1]};
        ge   = rem2 >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= ge ? pce_pkg::LEN_W'(rem2 - {1'b0, i_den})
                            : pce_pkg::LEN_W'(rem2);
                r_quo <= {r_quo[pce_pkg::COORD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pce_pkg::DIV_CNT_W'(pce_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/polyline_clip_end.sv
// Trims a polyline from its end by clip_distance (8 fraction bits). Points are
// taken one per cycle into a 64-entry point memory; points beyond it are dropped
// and every result of that polyline carries out_overflow. The final point starts
// the trim, during which the input is stalled. Each walked segment runs its
// bookkeeping and memory reads, then two squares and a square root on one shared
// shift-add multiplier and one root unit; the segment that holds the cut adds four
// products and two divisions. The remaining points then leave one at a time, read
// back from the memory, each held until its transfer is taken.
module polyline_clip_end (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pce_pkg::DIST_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pce_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pce_pkg::t_out_item                  o_out
);

    pce_pkg::t_state                r_state, n_state;
    logic [pce_pkg::CNT_W-1:0]      r_count, n_count;
    logic                           r_ovf, n_ovf;
    logic [pce_pkg::DIST_W-1:0]     r_dist;
    logic [pce_pkg::DIST_W-1:0]     r_d, n_d;
    logic [pce_pkg::CNT_W-1:0]      r_n, n_n;
    logic [pce_pkg::CNT_W-1:0]      r_k, n_k;
    logic                           r_kick, n_kick;
    logic signed [31:0]             r_px, n_px, r_py, n_py;
    logic signed [32:0]             r_vx, n_vx, r_vy, n_vy;
    logic [63:0]                    r_sqx, n_sqx;
    logic [64:0]                    r_ssum, n_ssum;
    logic [pce_pkg::LEN_W-1:0]      r_len, n_len;
    logic [pce_pkg::MUL_P_W-1:0]    r_prod, n_prod;
    logic [pce_pkg::NUM_W-1:0]      r_num, n_num;
    logic                           r_neg, n_neg;
    logic [31:0]                    r_nx, n_nx;
    logic                           r_out_valid, n_out_valid;
    pce_pkg::t_out_item             r_out, n_out;

    logic                           ram_we;
    logic [pce_pkg::CNT_W-1:0]      ram_waddr;
    logic [pce_pkg::POINT_W-1:0]    ram_wdata;
    logic [pce_pkg::CNT_W-1:0]      ram_raddr;
    logic [pce_pkg::POINT_W-1:0]    ram_rdata;

    logic                           mul_done, sqrt_done, div_done, sqrt_rem_nz;
    logic [pce_pkg::MUL_A_W-1:0]    mul_a;
    logic [pce_pkg::MUL_B_W-1:0]    mul_b;
    logic [pce_pkg::MUL_P_W-1:0]    mul_prod;
    logic [pce_pkg::LEN_W-1:0]      sqrt_root;
    logic [31:0]                    div_quo;
    logic                           mul_state;

    logic [32:0]                    vx_abs, vy_abs;
    logic [31:0]                    px_abs, py_abs;
    logic                           sel_y, sp, sv;
    logic [pce_pkg::NUM_W:0]        term_p, term_v, sum;
    logic [31:0]                    q_signed;

    pce_ram #(.WIDTH(pce_pkg::POINT_W), .DEPTH(pce_pkg::MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[pce_pkg::ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[pce_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    pce_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && mul_state),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pce_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kick && r_state == pce_pkg::S_SQRT),
        .i_x      ({1'b0, r_ssum, 16'b0}),
        .o_done   (sqrt_done),
        .o_root   (sqrt_root),
        .o_rem_nz (sqrt_rem_nz)
    );

    pce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick && (r_state == pce_pkg::S_DVX || r_state == pce_pkg::S_DVY)),
        .i_num   (r_num),
        .i_den   (r_len),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        vx_abs   = r_vx[32] ? -r_vx : r_vx;
        vy_abs   = r_vy[32] ? -r_vy : r_vy;
        px_abs   = r_px[31] ? 32'(-r_px) : 32'(r_px);
        py_abs   = r_py[31] ? 32'(-r_py) : 32'(r_py);
        sel_y    = r_state == pce_pkg::S_MPY || r_state == pce_pkg::S_MVY;
        sp       = sel_y ? r_py[31] : r_px[31];
        sv       = sel_y ? r_vy[32] : r_vx[32];
        mul_state = r_state == pce_pkg::S_SQX || r_state == pce_pkg::S_SQY
                 || r_state == pce_pkg::S_MPX || r_state == pce_pkg::S_MVX
                 || r_state == pce_pkg::S_MPY || r_state == pce_pkg::S_MVY;
        case (r_state)
            pce_pkg::S_SQX: begin
                mul_a = pce_pkg::MUL_A_W'(vx_abs[31:0]);
                mul_b = vx_abs[31:0];
            end
            pce_pkg::S_SQY: begin
                mul_a = pce_pkg::MUL_A_W'(vy_abs[31:0]);
                mul_b = vy_abs[31:0];
            end
            pce_pkg::S_MPX: begin
                mul_a = r_len;
                mul_b = px_abs;
            end
            pce_pkg::S_MPY: begin
                mul_a = r_len;
                mul_b = py_abs;
            end
            pce_pkg::S_MVX: begin
                mul_a = pce_pkg::MUL_A_W'(r_d);
                mul_b = vx_abs[31:0];
            end
            default: begin
                mul_a = pce_pkg::MUL_A_W'(r_d);
                mul_b = vy_abs[31:0];
            end
        endcase
        term_p   = sp ? -{2'b0, r_prod} : {2'b0, r_prod};
        term_v   = sv ? -{2'b0, mul_prod} : {2'b0, mul_prod};
        sum      = term_p + term_v;
        q_signed = r_neg ? -div_quo : div_quo;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_d         = r_d;
        n_n         = r_n;
        n_k         = r_k;
        n_kick      = 1'b0;
        n_px        = r_px;
        n_py        = r_py;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_sqx       = r_sqx;
        n_ssum      = r_ssum;
        n_len       = r_len;
        n_prod      = r_prod;
        n_num       = r_num;
        n_neg       = r_neg;
        n_nx        = r_nx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_count;
        ram_wdata   = {i_in.point_y, i_in.point_x};
        ram_raddr   = r_n - 1'b1;
        case (r_state)
            pce_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (r_count < pce_pkg::CNT_W'(pce_pkg::MAX_POINTS)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.is_final) begin
                        n_n     = n_count;
                        n_d     = r_dist;
                        n_state = pce_pkg::S_CHK;
                    end
                end
            end
            pce_pkg::S_CHK: begin
                n_k = '0;
                if (r_n == '0) begin
                    n_state = pce_pkg::S_EEMP;
                end else if (r_d == '0) begin
                    n_state = pce_pkg::S_ERD;
                end else begin
                    n_state = pce_pkg::S_RDP;
                end
            end
            pce_pkg::S_RDP: begin
                n_px      = ram_rdata[31:0];
                n_py      = ram_rdata[63:32];
                n_n       = r_n - 1'b1;
                ram_raddr = r_n - pce_pkg::CNT_W'(2);
                n_state   = (r_n == pce_pkg::CNT_W'(1)) ? pce_pkg::S_EEMP : pce_pkg::S_RDQ;
            end
            pce_pkg::S_RDQ: begin
                n_vx    = 33'(signed'(ram_rdata[31:0])) - 33'(r_px);
                n_vy    = 33'(signed'(ram_rdata[63:32])) - 33'(r_py);
                n_kick  = 1'b1;
                n_state = pce_pkg::S_SQX;
            end
            pce_pkg::S_SQX: begin
                if (mul_done) begin
                    n_sqx   = mul_prod[63:0];
                    n_kick  = 1'b1;
                    n_state = pce_pkg::S_SQY;
                end
            end
            pce_pkg::S_SQY: begin
                if (mul_done) begin
                    n_ssum  = {1'b0, r_sqx} + {1'b0, mul_prod[63:0]};
                    n_kick  = 1'b1;
                    n_state = pce_pkg::S_SQRT;
                end
            end
            pce_pkg::S_SQRT: begin
                if (sqrt_done) begin
                    n_len = sqrt_root;
                    if (sqrt_root > {1'b0, r_d}
                        || (sqrt_root == {1'b0, r_d} && sqrt_rem_nz)) begin
                        n_kick  = 1'b1;
                        n_state = pce_pkg::S_MPX;
                    end else begin
                        n_d     = r_d - sqrt_root[pce_pkg::DIST_W-1:0];
                        n_state = pce_pkg::S_CHK;
                    end
                end
            end
            pce_pkg::S_MPX, pce_pkg::S_MPY: begin
                if (mul_done) begin
                    n_prod  = mul_prod;
                    n_kick  = 1'b1;
                    n_state = (r_state == pce_pkg::S_MPX) ? pce_pkg::S_MVX : pce_pkg::S_MVY;
                end
            end
            pce_pkg::S_MVX, pce_pkg::S_MVY: begin
                if (mul_done) begin
                    n_neg   = sum[pce_pkg::NUM_W];
                    n_num   = sum[pce_pkg::NUM_W] ? pce_pkg::NUM_W'(-sum)
                                                  : sum[pce_pkg::NUM_W-1:0];
                    n_kick  = 1'b1;
                    n_state = (r_state == pce_pkg::S_MVX) ? pce_pkg::S_DVX : pce_pkg::S_DVY;
                end
            end
            pce_pkg::S_DVX: begin
                if (div_done) begin
                    n_nx    = q_signed;
                    n_kick  = 1'b1;
                    n_state = pce_pkg::S_MPY;
                end
            end
            pce_pkg::S_DVY: begin
                if (div_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_n;
                    ram_wdata = {q_signed, r_nx};
                    n_n       = r_n + 1'b1;
                    n_k       = '0;
                    n_state   = pce_pkg::S_ERD;
                end
            end
            pce_pkg::S_ERD: begin
                ram_raddr = r_k;
                n_state   = pce_pkg::S_ELD;
            end
            pce_pkg::S_ELD: begin
                n_out.out_x        = ram_rdata[31:0];
                n_out.out_y        = ram_rdata[63:32];
                n_out.out_last     = (r_k + 1'b1) == r_n;
                n_out.out_empty    = 1'b0;
                n_out.out_overflow = r_ovf;
                n_out_valid        = 1'b1;
                n_state            = pce_pkg::S_HOLD;
            end
            pce_pkg::S_EEMP: begin
                n_out.out_x        = '0;
                n_out.out_y        = '0;
                n_out.out_last     = 1'b1;
                n_out.out_empty    = 1'b1;
                n_out.out_overflow = r_ovf;
                n_out_valid        = 1'b1;
                n_state            = pce_pkg::S_HOLD;
            end
            pce_pkg::S_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out.out_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = pce_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = pce_pkg::S_ERD;
                    end
                end
            end
            default: begin
                n_state = pce_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pce_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_dist      <= '0;
            r_d         <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_d         <= n_d;
            r_n         <= n_n;
            r_k         <= n_k;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_dist <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px   <= n_px;
        r_py   <= n_py;
        r_vx   <= n_vx;
        r_vy   <= n_vy;
        r_sqx  <= n_sqx;
        r_ssum <= n_ssum;
        r_len  <= n_len;
        r_prod <= n_prod;
        r_num  <= n_num;
        r_neg  <= n_neg;
        r_nx   <= n_nx;
        r_out  <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_state != pce_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_no_out_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("result pending while points are being loaded");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pce_pkg::CNT_W'(pce_pkg::MAX_POINTS))
        else $error("point count beyond store depth");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out.out_last) |=> (!o_in_stall && r_count == '0))
        else $error("input not reopened after the last result");
`endif

endmodule
